// ===== rtl/pqa_pkg.sv =====
// shared types and constants for the aging priority queue
`default_nettype none

package pqa_pkg;

    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int CAP_W      = 5;
    localparam int THR_W      = 16;
    localparam int OCC_W      = 5;
    localparam int SEQ_W      = 32;
    localparam int AGE_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [AGE_W-1:0] AGE_MAX       = '1;
    localparam logic [CAP_W-1:0] CAP_RESET     = CAP_W'(16);
    localparam logic [THR_W-1:0] THR_RESET     = THR_W'(1000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(1);

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH     = 3'd0,
        MODE_POP      = 3'd1,
        MODE_TICK     = 3'd2,
        MODE_SHUTDOWN = 3'd3,
        MODE_ABORT    = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 3'd0,
        ST_REFUSED  = 3'd1,
        ST_GRANTED  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_ABORTED  = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    addr_clr;
        logic    scan_rd;
        logic    find_step;
        logic    push_wr;
        logic    grant;
        logic    set_closed;
        logic    set_aborted;
        logic    res_ld;
        logic    res_grant;
        status_t res_code;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic closed;
        logic aborted;
        logic empty;
        logic full;
        logic slot_free;
        logic addr_last;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/pqa_ctrl.sv =====
// sequencing state machine for the aging priority queue
`default_nettype none

module pqa_ctrl
    import pqa_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [MODE_W-1:0] s_mode,
    input  wire stat_t             stat,
    output cmd_t                   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_DRAIN1,
        S_DRAIN2,
        S_GRANT,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    status_t res_code_reg, res_code_next;
    logic    pop_reg, pop_next;
    logic    accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next    = state_reg;
        res_code_next = res_code_reg;
        pop_next      = pop_reg;
        cmd           = '0;
        cmd.res_code  = res_code_reg;
        cmd.res_grant = pop_reg && (res_code_reg == ST_GRANTED);
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    pop_next = 1'b0;
                    unique case (mode_t'(s_mode))
                        MODE_PUSH: begin
                            if (stat.closed || stat.full) begin
                                res_code_next = ST_REFUSED;
                                state_next    = S_DONE;
                            end else begin
                                res_code_next = ST_ACCEPTED;
                                cmd.addr_clr  = 1'b1;
                                state_next    = S_FIND;
                            end
                        end
                        MODE_POP: begin
                            if (stat.aborted) begin
                                res_code_next = ST_ABORTED;
                                state_next    = S_DONE;
                            end else if (stat.empty) begin
                                res_code_next = ST_EMPTY;
                                state_next    = S_DONE;
                            end else begin
                                res_code_next = ST_GRANTED;
                                pop_next      = 1'b1;
                                cmd.addr_clr  = 1'b1;
                                state_next    = S_SCAN;
                            end
                        end
                        MODE_TICK: begin
                            res_code_next = ST_ACCEPTED;
                            cmd.addr_clr  = 1'b1;
                            state_next    = S_SCAN;
                        end
                        MODE_SHUTDOWN: begin
                            res_code_next  = ST_ACCEPTED;
                            cmd.set_closed = 1'b1;
                            state_next     = S_DONE;
                        end
                        MODE_ABORT: begin
                            res_code_next   = ST_ACCEPTED;
                            cmd.set_aborted = 1'b1;
                            state_next      = S_DONE;
                        end
                        default: begin
                            res_code_next = ST_REFUSED;
                            state_next    = S_DONE;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (stat.slot_free) begin
                    cmd.push_wr = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    cmd.find_step = 1'b1;
                end
            end
            S_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (stat.addr_last) begin
                    state_next = S_DRAIN1;
                end
            end
            S_DRAIN1: begin
                state_next = S_DRAIN2;
            end
            S_DRAIN2: begin
                state_next = pop_reg ? S_GRANT : S_DONE;
            end
            S_GRANT: begin
                cmd.grant  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.res_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            res_code_reg <= ST_ACCEPTED;
            pop_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            res_code_reg <= res_code_next;
            pop_reg      <= pop_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pqa_datapath.sv =====
// entry memory, scan pipeline, flags and result register of the aging queue
`default_nettype none

module pqa_datapath
    import pqa_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int HANDLE_BITS   = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [MODE_W-1:0]        s_mode,
    input  wire logic [HANDLE_BITS-1:0]   s_task_handle,
    input  wire logic [PRIORITY_BITS-1:0] s_priority_req,
    input  wire logic                     cfg_wr,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    input  wire cmd_t                     cmd,
    output stat_t                         stat,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [STATUS_W-1:0]           m_status,
    output logic [HANDLE_BITS-1:0]        m_granted_handle,
    output logic [OCC_W-1:0]              m_occupancy
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef struct packed {
        logic [HANDLE_BITS-1:0]   handle;
        logic [PRIORITY_BITS-1:0] prio;
        logic [SEQ_W-1:0]         seq;
        logic [AGE_W-1:0]         age;
        logic                     aged;
    } entry_t;

    entry_t mem [QUEUE_DEPTH];

    // configuration
    logic [CAP_W-1:0] cap_reg;
    logic [THR_W-1:0] thr_reg;

    // queue state
    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [SEQ_W-1:0]       next_seq_reg;
    logic                   closed_reg;
    logic                   aborted_reg;

    // current operation
    mode_t                    op_mode_reg;
    logic [HANDLE_BITS-1:0]   op_handle_reg;
    logic [PRIORITY_BITS-1:0] op_prio_reg;
    logic [IDX_W-1:0]         addr_reg;

    // scan pipeline
    logic                     s1_en_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic                     s1_vld_reg;
    entry_t                   rd_data_reg;
    logic                     s1_aged;
    logic [SEQ_W-1:0]         s1_dist;
    entry_t                   s1_wr_data;
    logic                     s1_wr;

    logic                     s2_en_reg;
    logic                     s2_vld_reg;
    logic                     s2_aged_reg;
    logic [PRIORITY_BITS-1:0] s2_prio_reg;
    logic [SEQ_W-1:0]         s2_dist_reg;
    logic [HANDLE_BITS-1:0]   s2_handle_reg;
    logic [IDX_W-1:0]         s2_idx_reg;
    logic                     s2_above;

    logic                     best_vld_reg;
    logic                     best_aged_reg;
    logic [PRIORITY_BITS-1:0] best_prio_reg;
    logic [SEQ_W-1:0]         best_dist_reg;
    logic [HANDLE_BITS-1:0]   best_handle_reg;
    logic [IDX_W-1:0]         best_idx_reg;

    // result register
    logic                     m_valid_reg;
    status_t                  m_status_reg;
    logic [HANDLE_BITS-1:0]   m_handle_reg;
    logic [OCC_W-1:0]         m_occ_reg;

    entry_t                   push_data;

    assign stat.closed    = closed_reg;
    assign stat.aborted   = aborted_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (CMP_W'(count_reg) >= CMP_W'(cap_reg))
                            || (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.slot_free = !valid_reg[addr_reg];
    assign stat.addr_last = (addr_reg == IDX_W'(QUEUE_DEPTH - 1));
    assign stat.out_busy  = m_valid_reg && !m_ready;

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_granted_handle = m_handle_reg;
    assign m_occupancy      = m_occ_reg;

    always_comb begin
        push_data.handle = op_handle_reg;
        push_data.prio   = op_prio_reg;
        push_data.seq    = next_seq_reg;
        push_data.age    = '0;
        push_data.aged   = 1'b0;
    end

    // stage 1: aging update and arrival distance
    always_comb begin
        s1_aged    = rd_data_reg.aged || (rd_data_reg.age > thr_reg);
        s1_dist    = next_seq_reg - rd_data_reg.seq;
        s1_wr_data = rd_data_reg;
        s1_wr      = 1'b0;
        if (op_mode_reg == MODE_TICK) begin
            if (rd_data_reg.age != AGE_MAX) begin
                s1_wr_data.age = rd_data_reg.age + AGE_W'(1);
            end
            s1_wr = s1_en_reg && s1_vld_reg;
        end else begin
            s1_wr_data.aged = s1_aged;
            s1_wr = s1_en_reg && s1_vld_reg;
        end
    end

    // stage 2: rank against the best so far
    always_comb begin
        if (s2_aged_reg != best_aged_reg) begin
            s2_above = s2_aged_reg;
        end else if (!s2_aged_reg && (s2_prio_reg != best_prio_reg)) begin
            s2_above = s2_prio_reg > best_prio_reg;
        end else begin
            s2_above = s2_dist_reg > best_dist_reg;
        end
    end

    // entry memory, one read and one write port
    always_ff @(posedge aclk) begin
        if (cmd.push_wr) begin
            mem[addr_reg] <= push_data;
        end else if (s1_wr) begin
            mem[s1_idx_reg] <= s1_wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= CAP_RESET;
            thr_reg      <= THR_RESET;
            valid_reg    <= '0;
            count_reg    <= '0;
            next_seq_reg <= '0;
            closed_reg   <= 1'b0;
            aborted_reg  <= 1'b0;
            op_mode_reg  <= MODE_PUSH;
            addr_reg     <= '0;
            s1_en_reg    <= 1'b0;
            s2_en_reg    <= 1'b0;
            best_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr && (cfg_index == CFG_CAPACITY)) begin
                cap_reg <= cfg_data[CAP_W-1:0];
            end
            if (cfg_wr && (cfg_index == CFG_THRESHOLD)) begin
                thr_reg <= cfg_data[THR_W-1:0];
            end

            if (cmd.load) begin
                op_mode_reg <= mode_t'(s_mode);
            end
            if (cmd.set_closed) begin
                closed_reg <= 1'b1;
            end
            if (cmd.set_aborted) begin
                aborted_reg <= 1'b1;
            end

            priority if (cmd.addr_clr) begin
                addr_reg <= '0;
            end else if (cmd.scan_rd || cmd.find_step) begin
                addr_reg <= addr_reg + IDX_W'(1);
            end

            if (cmd.push_wr) begin
                valid_reg[addr_reg] <= 1'b1;
                count_reg           <= count_reg + CNT_W'(1);
                next_seq_reg        <= next_seq_reg + SEQ_W'(1);
            end else if (cmd.grant) begin
                valid_reg[best_idx_reg] <= 1'b0;
                count_reg               <= count_reg - CNT_W'(1);
            end

            s1_en_reg <= cmd.scan_rd;
            s2_en_reg <= s1_en_reg && (op_mode_reg == MODE_POP);

            priority if (cmd.addr_clr) begin
                best_vld_reg <= 1'b0;
            end else if (s2_en_reg && s2_vld_reg && (!best_vld_reg || s2_above)) begin
                best_vld_reg <= 1'b1;
            end

            priority if (cmd.res_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_handle_reg <= s_task_handle;
            op_prio_reg   <= s_priority_req;
        end

        s1_idx_reg <= addr_reg;
        s1_vld_reg <= valid_reg[addr_reg];

        s2_vld_reg    <= s1_vld_reg;
        s2_aged_reg   <= s1_aged;
        s2_prio_reg   <= rd_data_reg.prio;
        s2_dist_reg   <= s1_dist;
        s2_handle_reg <= rd_data_reg.handle;
        s2_idx_reg    <= s1_idx_reg;

        if (s2_en_reg && s2_vld_reg && (!best_vld_reg || s2_above)) begin
            best_aged_reg   <= s2_aged_reg;
            best_prio_reg   <= s2_prio_reg;
            best_dist_reg   <= s2_dist_reg;
            best_handle_reg <= s2_handle_reg;
            best_idx_reg    <= s2_idx_reg;
        end

        if (cmd.res_ld) begin
            m_status_reg <= cmd.res_code;
            m_handle_reg <= cmd.res_grant ? best_handle_reg : '0;
            m_occ_reg    <= OCC_W'(count_reg);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/priority_queue_with_aging.sv =====
// top level of the bounded task queue with priorities and aging
// throughput: one item at a time, set by the one-entry-per-cycle scan of the entry memory
// reset: synchronous active-low aresetn empties the queue, clears shutdown/abort
//   and restores capacity 16 and age threshold 1000
`default_nettype none

module priority_queue_with_aging
    import pqa_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int HANDLE_BITS   = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // command input
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [MODE_W-1:0]        s_mode,
    input  wire logic [HANDLE_BITS-1:0]   s_task_handle,
    input  wire logic [PRIORITY_BITS-1:0] s_priority_req,
    // result output
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [STATUS_W-1:0]           m_status,
    output logic [HANDLE_BITS-1:0]        m_granted_handle,
    output logic [OCC_W-1:0]              m_occupancy,
    // configuration writes
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // controller: decodes the command, walks the scan and issues the result
    pqa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: entry memory, valid bits, ranking pipeline, result register
    pqa_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS),
        .HANDLE_BITS   (HANDLE_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_mode           (s_mode),
        .s_task_handle    (s_task_handle),
        .s_priority_req   (s_priority_req),
        .cfg_wr           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_granted_handle (m_granted_handle),
        .m_occupancy      (m_occupancy)
    );

    // a handle only travels with a grant
    a_handle_only_on_grant: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_GRANTED)) |-> (m_granted_handle == '0)
    ) else $error("nonzero handle on a result that is not a grant");

    // the input side closes right after a transfer until its result is queued
    a_one_item_in_flight: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready
    ) else $error("second command taken while one is in progress");

    // an empty pop leaves nothing queued
    a_empty_means_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_EMPTY)) |-> (m_occupancy == '0)
    ) else $error("empty status with nonzero occupancy");

    // a push write and a grant never touch the entry state in the same cycle
    a_cmd_exclusive: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !(cmd.push_wr && cmd.grant)
    ) else $error("push write and grant in the same cycle");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench for the aging priority task queue
`timescale 1ns / 100ps

module tb_top
    import pqa_pkg::*;
();

    localparam int DEPTH       = 16;
    localparam int PRIO_W      = 8;
    localparam int HANDLE_W    = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;
    // mode codes the block does not know, refused without a state change
    localparam logic [MODE_W-1:0]    MODE_UNUSED_LO  = MODE_W'(5);
    localparam logic [MODE_W-1:0]    MODE_UNUSED_MID = MODE_W'(6);
    localparam logic [MODE_W-1:0]    MODE_UNUSED_HI  = MODE_W'(7);
    // register index with nothing behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = CFG_IDX_W'(3);

    typedef struct {
        status_t             status;
        logic [HANDLE_W-1:0] handle;
        logic [OCC_W-1:0]    occupancy;
    } result_t;

    // shadow copy of the queue: computes the result of every accepted command
    // and holds the results still owed by the block, oldest first
    class queue_scoreboard;
        logic [CAP_W-1:0]    capacity;
        logic [THR_W-1:0]    threshold;
        bit                  slot_used   [DEPTH];
        logic [HANDLE_W-1:0] slot_handle [DEPTH];
        logic [PRIO_W-1:0]   slot_prio   [DEPTH];
        logic [SEQ_W-1:0]    slot_seq    [DEPTH];
        logic [AGE_W-1:0]    slot_age    [DEPTH];
        bit                  slot_aged   [DEPTH];
        logic [SEQ_W-1:0]    arrival;
        bit                  closed;
        bit                  aborted;
        result_t             owed_results [$];
        int                  faults;

        function new();
            capacity  = CAP_RESET;
            threshold = THR_RESET;
            arrival   = '0;
            closed    = 1'b0;
            aborted   = 1'b0;
            faults    = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_CAPACITY) begin
                capacity = data[CAP_W-1:0];
            end else if (idx == CFG_THRESHOLD) begin
                threshold = data[THR_W-1:0];
            end
        endfunction

        function int queued();
            int n;
            n = 0;
            foreach (slot_used[i]) if (slot_used[i]) n++;
            return n;
        endfunction

        // aged beats unaged; among unaged the larger priority; then oldest arrival,
        // measured as distance back from the next arrival number so wrap is harmless
        function bit outranks(int a, int b);
            logic [SEQ_W-1:0] dist_a, dist_b;
            if (slot_aged[a] != slot_aged[b]) return slot_aged[a];
            if (!slot_aged[a] && slot_prio[a] != slot_prio[b])
                return slot_prio[a] > slot_prio[b];
            dist_a = arrival - slot_seq[a];
            dist_b = arrival - slot_seq[b];
            return dist_a > dist_b;
        endfunction

        function void note_command(logic [MODE_W-1:0] mode, logic [HANDLE_W-1:0] handle,
                                   logic [PRIO_W-1:0] prio);
            result_t r;
            int      n;
            int      slot;
            int      best;
            n        = queued();
            slot     = -1;
            best     = -1;
            r.status = ST_ACCEPTED;
            r.handle = '0;
            case (mode)
                MODE_PUSH: begin
                    if (closed || n >= capacity || n >= DEPTH) begin
                        r.status = ST_REFUSED;
                    end else begin
                        for (int i = 0; i < DEPTH; i++)
                            if (!slot_used[i] && slot < 0) slot = i;
                        slot_used[slot]   = 1'b1;
                        slot_handle[slot] = handle;
                        slot_prio[slot]   = prio;
                        slot_seq[slot]    = arrival;
                        slot_age[slot]    = '0;
                        slot_aged[slot]   = 1'b0;
                        arrival           = arrival + 1'b1;
                    end
                end
                MODE_POP: begin
                    if (aborted) begin
                        r.status = ST_ABORTED;
                    end else if (n == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        // aged marks stick once set
                        for (int i = 0; i < DEPTH; i++)
                            if (slot_used[i] && slot_age[i] > threshold) slot_aged[i] = 1'b1;
                        for (int i = 0; i < DEPTH; i++)
                            if (slot_used[i] && (best < 0 || outranks(i, best))) best = i;
                        r.status        = ST_GRANTED;
                        r.handle        = slot_handle[best];
                        slot_used[best] = 1'b0;
                    end
                end
                MODE_TICK: begin
                    for (int i = 0; i < DEPTH; i++)
                        if (slot_used[i] && slot_age[i] != AGE_MAX) slot_age[i]++;
                end
                MODE_SHUTDOWN: closed = 1'b1;
                MODE_ABORT:    aborted = 1'b1;
                default:       r.status = ST_REFUSED;
            endcase
            r.occupancy = OCC_W'(queued());
            owed_results = {owed_results, r};
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] handle,
                                   logic [OCC_W-1:0] occupancy);
            result_t e;
            if (owed_results.size() == 0) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("unexpected result: status %0d handle %h occupancy %0d",
                             status, handle, occupancy);
                return;
            end
            e = owed_results.pop_front();
            if (status !== e.status || handle !== e.handle || occupancy !== e.occupancy) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display({"mismatch: expected status %0d handle %h occupancy %0d,",
                              " got status %0d handle %h occupancy %0d"},
                             e.status, e.handle, e.occupancy, status, handle, occupancy);
            end
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [MODE_W-1:0]     s_mode         = '0;
    logic [HANDLE_W-1:0]   s_task_handle  = '0;
    logic [PRIO_W-1:0]     s_priority_req = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [HANDLE_W-1:0]   m_granted_handle;
    logic [OCC_W-1:0]      m_occupancy;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    queue_scoreboard sb = new();
    bit              no_idle = 1'b0;   // set for the closing stretch of the run
    int              cycles  = 0;

    priority_queue_with_aging dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_task_handle    (s_task_handle),
        .s_priority_req   (s_priority_req),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_granted_handle (m_granted_handle),
        .m_occupancy      (m_occupancy),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // every result transfer is checked against the oldest owed result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_granted_handle, m_occupancy);
    end

    // result side backpressure: short stall bursts, sometimes long calm stretches
    initial begin
        int pick;
        forever begin
            @(negedge aclk);
            pick = $urandom_range(0, 15);
            if (!no_idle && pick < 3) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
                if (pick == 15) repeat (40) @(negedge aclk);
            end
        end
    end

    // drive one command and hold it until the block takes it; valid stays high
    // on return so a back-to-back command does not drop it
    task automatic send_command(input logic [MODE_W-1:0] mode,
                                input logic [HANDLE_W-1:0] handle,
                                input logic [PRIO_W-1:0] prio);
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_task_handle  <= handle;
        s_priority_req <= prio;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_command(mode, handle, prio);
    endtask

    // sender idles in bursts now and then
    task automatic issue(input logic [MODE_W-1:0] mode, input logic [HANDLE_W-1:0] handle,
                         input logic [PRIO_W-1:0] prio);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge aclk);
        end
        send_command(mode, handle, prio);
    endtask

    // stop sending and wait for every owed result
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.owed_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.write_register(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // random command mix; priorities lean toward a few values so ties happen
    task automatic random_commands(input int count, input int push_w, input int pop_w,
                                   input int tick_w);
        logic [MODE_W-1:0] mode;
        logic [PRIO_W-1:0] prio;
        int                pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < push_w)
                mode = MODE_PUSH;
            else if (pick < push_w + pop_w)
                mode = MODE_POP;
            else if (pick < push_w + pop_w + tick_w)
                mode = MODE_TICK;
            else
                mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            case ($urandom_range(0, 3))
                0, 1: prio = PRIO_W'($urandom);
                2:    prio = $urandom_range(0, 1) ? '1 : '0;
                default: prio = PRIO_W'($urandom_range(100, 103));
            endcase
            issue(mode, HANDLE_W'($urandom), prio);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty queue, unknown modes, field extremes and priority ties
        issue(MODE_POP, '0, '0);
        issue(MODE_TICK, '1, '1);
        issue(MODE_UNUSED_LO, '0, '0);
        issue(MODE_UNUSED_MID, '1, '1);
        issue(MODE_UNUSED_HI, 16'h5a5a, 8'ha5);
        issue(MODE_PUSH, 16'hffff, 8'hff);
        issue(MODE_PUSH, 16'h0000, 8'h00);
        issue(MODE_PUSH, 16'h1234, 8'hff);   // ties with the first push, loses on arrival
        issue(MODE_PUSH, 16'h5678, 8'h00);
        issue(MODE_PUSH, 16'habcd, 8'h80);
        issue(MODE_TICK, '0, '0);
        repeat (6) issue(MODE_POP, '0, '0);  // last one finds the queue empty

        // reset settings: capacity 16, threshold 1000
        random_commands(150, 45, 30, 20);
        drain();

        // small capacity, short threshold so entries get promoted; upper data bits
        // of the capacity write are ignored
        write_config(CFG_CAPACITY, 16'hffe4);
        write_config(CFG_THRESHOLD, 16'd3);
        random_commands(70, 40, 25, 30);
        drain();                             // sender waits out every owed result
        random_commands(70, 40, 25, 30);
        drain();

        // capacity zero refuses all pushes; threshold zero ages after one tick
        write_config(CFG_CAPACITY, 16'd0);
        write_config(CFG_THRESHOLD, 16'd0);
        random_commands(60, 40, 25, 30);
        drain();

        write_config(CFG_CAPACITY, 16'd1);
        write_config(CFG_THRESHOLD, 16'd1);
        random_commands(90, 45, 25, 25);
        drain();

        // capacity above the depth: the queue fills to all sixteen slots
        write_config(CFG_CAPACITY, 16'd20);
        write_config(CFG_THRESHOLD, 16'd65534);
        random_commands(150, 55, 25, 15);
        drain();

        // a write to the unused index changes nothing
        write_config(CFG_SPARE, 16'hffff);
        write_config(CFG_CAPACITY, 16'd16);
        write_config(CFG_THRESHOLD, 16'hffff);
        random_commands(90, 45, 30, 20);
        drain();

        // closing stretch without idling: shutdown while entries wait, pops keep
        // granting, then abort makes every pop report aborted
        write_config(CFG_CAPACITY, 16'd9);
        write_config(CFG_THRESHOLD, 16'd2);
        no_idle = 1'b1;
        for (int k = 0; k < 150; k++) begin
            if (k == 60 || k == 100)
                issue(MODE_SHUTDOWN, HANDLE_W'($urandom), PRIO_W'($urandom));
            else if (k == 120 || k == 140)
                issue(MODE_ABORT, HANDLE_W'($urandom), PRIO_W'($urandom));
            else
                random_commands(1, 35, 35, 25);
        end
        drain();
        repeat (30) @(posedge aclk);

        if (sb.faults == 0 && sb.owed_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
